>>> design/grbu_pkg.sv
// Shared types, constants and activation functions of the gated recurrent blend unit.
package grbu_pkg;

	typedef logic signed [15:0] q412_t;
	typedef logic [12:0]        gate_t;
	typedef logic signed [13:0] cand_t;
	typedef logic [16:0]        mag_t;
	typedef logic [17:0]        mag2_t;
	typedef logic signed [29:0] prod_hp_t;
	typedef logic signed [27:0] prod_cd_t;
	typedef logic signed [31:0] acc_t;

	localparam gate_t Q_ONE  = 13'd4096;
	localparam acc_t  Q_HALF = 32'sd2048;

	localparam q412_t Q_MAX = 16'sh7FFF;
	localparam q412_t Q_MIN = -16'sh8000;

	function automatic q412_t sat16(input logic signed [16:0] s);
		if (s > 17'sd32767) begin
			return Q_MAX;
		end else if (s < -17'sd32768) begin
			return Q_MIN;
		end
		return q412_t'(s);
	endfunction

	function automatic mag_t abs_mag(input q412_t x);
		logic signed [16:0] e;
		e = {x[15], x};
		return x[15] ? mag_t'(-e) : mag_t'(e);
	endfunction

	function automatic gate_t sig_mag(input mag2_t m);
		if (m < 18'd4096) begin
			return gate_t'(m >> 2) + 13'd2048;
		end else if (m < 18'd9728) begin
			return gate_t'(m >> 3) + 13'd2560;
		end else if (m < 18'd20480) begin
			return gate_t'(m >> 5) + 13'd3456;
		end
		return Q_ONE;
	endfunction

endpackage

>>> design/grbu_in_if.sv
// Input channel: one element's previous hidden value, sums and biases.
interface grbu_in_if;
	logic              valid;
	logic              ready;
	grbu_pkg::q412_t   hidden_prev;
	grbu_pkg::q412_t   cand_sum;
	grbu_pkg::q412_t   gate_sum;
	grbu_pkg::q412_t   cand_bias;
	grbu_pkg::q412_t   gate_bias;

	modport source (output valid, hidden_prev, cand_sum, gate_sum, cand_bias, gate_bias,
		input ready);
	modport sink (input valid, hidden_prev, cand_sum, gate_sum, cand_bias, gate_bias,
		output ready);
endinterface

>>> design/grbu_out_if.sv
// Output channel: new hidden value, biased pre-activation and gate.
interface grbu_out_if;
	logic              valid;
	logic              ready;
	grbu_pkg::q412_t   hidden_new;
	grbu_pkg::q412_t   pre_activation;
	grbu_pkg::gate_t   gate_value;

	modport source (output valid, hidden_new, pre_activation, gate_value, input ready);
	modport sink (input valid, hidden_new, pre_activation, gate_value, output ready);
endinterface

>>> design/grbu_bias.sv
// Stage 1: add biases with saturation.
module grbu_bias (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  logic            rdy_dn,
	input  grbu_pkg::q412_t hidden_prev,
	input  grbu_pkg::q412_t cand_sum,
	input  grbu_pkg::q412_t gate_sum,
	input  grbu_pkg::q412_t cand_bias,
	input  grbu_pkg::q412_t gate_bias,
	output logic            rdy,
	output logic            vld_s1,
	output grbu_pkg::q412_t hp_s1,
	output grbu_pkg::q412_t pre_s1,
	output grbu_pkg::q412_t gin_s1
);
	import grbu_pkg::*;

	assign rdy = !vld_s1 || rdy_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vld) begin
			hp_s1  <= hidden_prev;
			pre_s1 <= sat16(17'(cand_sum) + 17'(cand_bias));
			gin_s1 <= sat16(17'(gate_sum) + 17'(gate_bias));
		end
	end
endmodule

>>> design/grbu_act.sv
// Stage 2: piecewise-linear sigmoid gate and tanh candidate.
module grbu_act (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  logic            rdy_dn,
	input  grbu_pkg::q412_t hp,
	input  grbu_pkg::q412_t pre,
	input  grbu_pkg::q412_t gin,
	output logic            rdy,
	output logic            vld_s2,
	output grbu_pkg::q412_t hp_s2,
	output grbu_pkg::q412_t pre_s2,
	output grbu_pkg::gate_t g_s2,
	output grbu_pkg::cand_t cand_s2
);
	import grbu_pkg::*;

	gate_t       g_y;
	gate_t       c_y;
	logic [13:0] c_t;
	gate_t       g_next;
	cand_t       cand_next;

	assign rdy = !vld_s2 || rdy_dn;

	always_comb begin
		g_y       = sig_mag({1'b0, abs_mag(gin)});
		g_next    = gin[15] ? Q_ONE - g_y : g_y;
		c_y       = sig_mag({abs_mag(pre), 1'b0});
		c_t       = {c_y, 1'b0} - 14'd4096;
		cand_next = pre[15] ? -$signed(c_t) : $signed(c_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy) begin
			vld_s2 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vld) begin
			hp_s2   <= hp;
			pre_s2  <= pre;
			g_s2    <= g_next;
			cand_s2 <= cand_next;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (g_s2 <= Q_ONE) && (cand_s2 <= 14'sd4096) && (cand_s2 >= -14'sd4096))
		else $error("activation out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && pre_s2[15] |-> !(cand_s2 > 14'sd0))
		else $error("tanh sign mismatch");
endmodule

>>> design/grbu_blend.sv
// Stages 3 and 4: blend products, round, clamp and hold the result.
module grbu_blend (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  logic            rdy_dn,
	input  grbu_pkg::q412_t hp,
	input  grbu_pkg::q412_t pre,
	input  grbu_pkg::gate_t g,
	input  grbu_pkg::cand_t cand,
	output logic            rdy,
	output logic            vld_s4,
	output grbu_pkg::q412_t hn_s4,
	output grbu_pkg::q412_t pre_s4,
	output grbu_pkg::gate_t g_s4
);
	import grbu_pkg::*;

	logic               vld_s3;
	prod_hp_t           php_s3;
	prod_cd_t           pcd_s3;
	q412_t              pre_s3;
	gate_t              g_s3;
	logic               rdy3;
	logic signed [13:0] w_hp;
	logic signed [13:0] w_cd;
	acc_t               acc;
	logic signed [19:0] q;
	q412_t              hn_next;

	assign rdy3 = !vld_s4 || rdy_dn;
	assign rdy  = !vld_s3 || rdy3;

	always_comb begin
		w_hp = $signed({1'b0, Q_ONE - g});
		w_cd = $signed({1'b0, g});
		acc  = acc_t'(php_s3) + acc_t'(pcd_s3) + Q_HALF;
		q    = 20'(acc >>> 12);
		if (q > 20'sd32767) begin
			hn_next = Q_MAX;
		end else if (q < -20'sd32768) begin
			hn_next = Q_MIN;
		end else begin
			hn_next = q412_t'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy) begin
				vld_s3 <= vld;
			end
			if (rdy3) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vld) begin
			php_s3 <= w_hp * hp;
			pcd_s3 <= w_cd * cand;
			pre_s3 <= pre;
			g_s3   <= g;
		end
		if (rdy3 && vld_s3) begin
			hn_s4  <= hn_next;
			pre_s4 <= pre_s3;
			g_s4   <= g_s3;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !rdy3 |=> vld_s3 && $stable(php_s3) && $stable(pcd_s3))
		else $error("stage 3 lost a stalled item");
endmodule

>>> design/gated_recurrent_blend_unit_core.sv
// Top level of the gated recurrent blend unit: four-stage element pipeline.
//
//   channel  direction  contents
//   din      sink       hidden_prev, cand_sum, gate_sum, cand_bias, gate_bias
//   dout     source     hidden_new, pre_activation, gate_value
//
// One transfer per cycle in and out while dout is ready; the stages are bias,
// activation, products, round and clamp. The two multipliers of stage 3 set the clock.
// arst_n clears the stage valid bits; payload registers are not reset.
// A stalled dout holds every occupied stage up to the first empty one; stages behind it keep advancing.
module gated_recurrent_blend_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	grbu_in_if.sink     din,
	grbu_out_if.source  dout
);
	import grbu_pkg::*;

	logic  vld_s1;
	logic  vld_s2;
	logic  rdy2;
	logic  rdy3;
	q412_t hp_s1;
	q412_t pre_s1;
	q412_t gin_s1;
	q412_t hp_s2;
	q412_t pre_s2;
	gate_t g_s2;
	cand_t cand_s2;

	grbu_bias u_bias (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld         (din.valid),
		.rdy_dn      (rdy2),
		.hidden_prev (din.hidden_prev),
		.cand_sum    (din.cand_sum),
		.gate_sum    (din.gate_sum),
		.cand_bias   (din.cand_bias),
		.gate_bias   (din.gate_bias),
		.rdy         (din.ready),
		.vld_s1      (vld_s1),
		.hp_s1       (hp_s1),
		.pre_s1      (pre_s1),
		.gin_s1      (gin_s1)
	);

	grbu_act u_act (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s1),
		.rdy_dn  (rdy3),
		.hp      (hp_s1),
		.pre     (pre_s1),
		.gin     (gin_s1),
		.rdy     (rdy2),
		.vld_s2  (vld_s2),
		.hp_s2   (hp_s2),
		.pre_s2  (pre_s2),
		.g_s2    (g_s2),
		.cand_s2 (cand_s2)
	);

	grbu_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s2),
		.rdy_dn (dout.ready),
		.hp     (hp_s2),
		.pre    (pre_s2),
		.g      (g_s2),
		.cand   (cand_s2),
		.rdy    (rdy3),
		.vld_s4 (dout.valid),
		.hn_s4  (dout.hidden_new),
		.pre_s4 (dout.pre_activation),
		.g_s4   (dout.gate_value)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> vld_s1)
		else $error("accepted transfer did not enter stage 1");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !rdy2 |=> vld_s1 && $stable(pre_s1) && $stable(gin_s1))
		else $error("stage 1 lost a stalled item");
	assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> dout.gate_value <= Q_ONE)
		else $error("gate out of range");
endmodule
